// ----- hw/rtl/lrs_pkg.sv -----
// Shared constants and command codes for the range-add / range-sum block.
package lrs_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned IndexW = 11;
  localparam int unsigned DataW  = 32;

  // Default number of array elements.
  localparam int unsigned MaxElementsDefault = 1024;

  // Command codes.
  localparam logic CmdAdd = 1'b0;
  localparam logic CmdSum = 1'b1;

endpackage

// ----- hw/rtl/lrs_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
module lrs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/lazy_range_add_range_sum.sv -----
// Top level of the range-add / range-sum block with a lazy segment tree.
//
// The block keeps a segment tree of 32-bit wrapping sums with pending adds over
// elements 1..active_count, clamped to 1..MaxElements. A command 0 transaction
// adds add_value to every element in [lo_index, hi_index] and returns nothing;
// a command 1 transaction returns the sum over the range in range_sum. Empty or
// fully outside ranges leave the tree unchanged and a query over them returns 0.
// One transaction is processed at a time by a sequencer that walks the tree with
// an explicit stack; node sums and pending adds live in two RAMs with a
// registered read port. Each visited node is read and evaluated; a pending add
// is applied to it and, except at a leaf, pushed to its children; each node
// that is split has its sum rebuilt from both children on return. After reset a
// clearing pass zeroes all 4*MaxElements entries of both RAMs, during which no
// transaction is taken; configuration writes are taken at any time.
module lazy_range_add_range_sum #(
  parameter int unsigned MaxElements = lrs_pkg::MaxElementsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration.
  input  logic                         cfg_we_i,
  input  logic [lrs_pkg::IndexW-1:0]   cfg_wdata_i,
  // Input channel.
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         command_i,
  input  logic [lrs_pkg::IndexW-1:0]   lo_index_i,
  input  logic [lrs_pkg::IndexW-1:0]   hi_index_i,
  input  logic signed [lrs_pkg::DataW-1:0] add_value_i,
  // Output channel.
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [lrs_pkg::DataW-1:0] range_sum_o
);

  import lrs_pkg::*;

  localparam int unsigned NodeDepth  = 4 * MaxElements;
  localparam int unsigned NodeW      = $clog2(NodeDepth);
  localparam int unsigned IdxW       = $clog2(MaxElements + 1);
  localparam int unsigned CmpW       = (IdxW > IndexW) ? IdxW : IndexW;
  localparam int unsigned StackDepth = $clog2(MaxElements);
  localparam int unsigned SpW        = $clog2(StackDepth + 1);
  localparam int unsigned StkIdxW    = (StackDepth > 1) ? $clog2(StackDepth) : 1;
  localparam int unsigned CountReset = (MaxElements > 2047) ? 2047 : MaxElements;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_CLEAR  = 13'b0000000000010,
    S_VISIT  = 13'b0000000000100,
    S_EVAL   = 13'b0000000001000,
    S_UPD    = 13'b0000000010000,
    S_CH0    = 13'b0000000100000,
    S_CH1    = 13'b0000001000000,
    S_DECIDE = 13'b0000010000000,
    S_RET    = 13'b0000100000000,
    S_REFL   = 13'b0001000000000,
    S_REFR   = 13'b0010000000000,
    S_REFW   = 13'b0100000000000,
    S_FIN    = 13'b1000000000000
  } state_e;

  // Control registers.
  state_e             state_q, state_d;
  logic [SpW-1:0]     sp_q, sp_d;
  logic [NodeW-1:0]   clr_q, clr_d;
  logic [IndexW-1:0]  active_count_q;
  logic               out_valid_q, out_valid_d;

  // Working registers of the current transaction and node.
  logic               cmd_q, cmd_d;
  logic [IndexW-1:0]  lo_q, lo_d, hi_q, hi_d;
  logic [DataW-1:0]   v_q, v_d;
  logic [NodeW-1:0]   nd_q, nd_d;
  logic [IdxW-1:0]    a_q, a_d, b_q, b_d;
  logic [DataW-1:0]   tot_q, tot_d;
  logic [DataW-1:0]   prod_q, prod_d;
  logic [DataW-1:0]   node_q, node_d;
  logic               cov_q, cov_d, outside_q, outside_d;
  logic [DataW-1:0]   ret_q, ret_d;
  logic [DataW-1:0]   acc_q, acc_d;
  logic [DataW-1:0]   left_q, left_d;
  logic [DataW-1:0]   res_q, res_d;

  // Stack of ancestor frames.
  logic [NodeW-1:0]   stk_nd_q [StackDepth];
  logic [IdxW-1:0]    stk_a_q  [StackDepth];
  logic [IdxW-1:0]    stk_b_q  [StackDepth];
  logic [DataW-1:0]   stk_s_q  [StackDepth];
  logic               stk_ph_q [StackDepth];
  logic               push, set_right;
  logic [StkIdxW-1:0] push_idx, top_idx;
  logic [SpW-1:0]     sp_dec;

  // RAM ports.
  logic               sum_we, pend_we;
  logic [NodeW-1:0]   sum_waddr, pend_waddr, sum_raddr, pend_raddr;
  logic [DataW-1:0]   sum_wdata, pend_wdata, sum_rdata, pend_rdata;

  // Derived values.
  logic [IdxW-1:0]    span;
  logic [IdxW:0]      mid_sum, top_mid_sum;
  logic [IdxW-1:0]    mid, top_mid, len;
  logic [CmpW-1:0]    a_x, b_x, lo_x, hi_x;
  logic               cov_w, outside_w, upd_w;
  logic [DataW-1:0]   p_tot;
  logic [NodeW-1:0]   left_nd, right_nd, top_right_nd;

  lrs_ram #(.Width(DataW), .Depth(NodeDepth)) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .waddr_i (sum_waddr),
    .wdata_i (sum_wdata),
    .raddr_i (sum_raddr),
    .rdata_o (sum_rdata)
  );

  lrs_ram #(.Width(DataW), .Depth(NodeDepth)) u_pend_ram (
    .clk_i   (clk_i),
    .we_i    (pend_we),
    .waddr_i (pend_waddr),
    .wdata_i (pend_wdata),
    .raddr_i (pend_raddr),
    .rdata_o (pend_rdata)
  );

  // Element count clamped to 1..MaxElements.
  always_comb begin
    if (active_count_q == '0) begin
      span = IdxW'(1);
    end else if (CmpW'(active_count_q) > CmpW'(MaxElements)) begin
      span = IdxW'(MaxElements);
    end else begin
      span = IdxW'(active_count_q);
    end
  end

  // Node geometry and range classification.
  assign mid_sum      = {1'b0, a_q} + {1'b0, b_q};
  assign mid          = mid_sum[IdxW:1];
  assign len          = b_q - a_q + IdxW'(1);
  assign left_nd      = {nd_q[NodeW-2:0], 1'b0};
  assign right_nd     = {nd_q[NodeW-2:0], 1'b1};
  assign a_x          = CmpW'(a_q);
  assign b_x          = CmpW'(b_q);
  assign lo_x         = CmpW'(lo_q);
  assign hi_x         = CmpW'(hi_q);
  assign cov_w        = (a_x >= lo_x) && (b_x <= hi_x);
  assign outside_w    = (hi_x < a_x) || (lo_x > b_x);
  assign p_tot        = pend_rdata + (((cmd_q == CmdAdd) && cov_w) ? v_q : '0);
  assign upd_w        = (pend_rdata != '0) || ((cmd_q == CmdAdd) && cov_w && (v_q != '0));

  assign sp_dec       = sp_q - SpW'(1);
  assign top_idx      = sp_dec[StkIdxW-1:0];
  assign push_idx     = sp_q[StkIdxW-1:0];
  assign top_mid_sum  = {1'b0, stk_a_q[top_idx]} + {1'b0, stk_b_q[top_idx]};
  assign top_mid      = top_mid_sum[IdxW:1];
  assign top_right_nd = {stk_nd_q[top_idx][NodeW-2:0], 1'b1};

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    sp_d        = sp_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q;
    cmd_d       = cmd_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    v_d         = v_q;
    nd_d        = nd_q;
    a_d         = a_q;
    b_d         = b_q;
    tot_d       = tot_q;
    prod_d      = prod_q;
    node_d      = node_q;
    cov_d       = cov_q;
    outside_d   = outside_q;
    ret_d       = ret_q;
    acc_d       = acc_q;
    left_d      = left_q;
    res_d       = res_q;
    push        = 1'b0;
    set_right   = 1'b0;
    sum_we      = 1'b0;
    pend_we     = 1'b0;
    sum_waddr   = nd_q;
    pend_waddr  = nd_q;
    sum_wdata   = '0;
    pend_wdata  = '0;
    sum_raddr   = nd_q;
    pend_raddr  = nd_q;
    in_stall_o  = 1'b1;

    // The output register drains independently of the sequencer.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        sum_we     = 1'b1;
        pend_we    = 1'b1;
        sum_waddr  = clr_q;
        pend_waddr = clr_q;
        clr_d      = clr_q + NodeW'(1);
        if (clr_q == NodeW'(NodeDepth - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_d = command_i;
          lo_d  = lo_index_i;
          hi_d  = hi_index_i;
          v_d   = add_value_i;
          nd_d  = NodeW'(1);
          a_d   = IdxW'(1);
          b_d   = span;
          sp_d  = '0;
          if (lo_index_i > hi_index_i) begin
            ret_d   = '0;
            state_d = (command_i == CmdSum) ? S_FIN : S_IDLE;
          end else begin
            state_d = S_VISIT;
          end
        end
      end
      S_VISIT: begin
        // Both RAMs are read at the current node.
        state_d = S_EVAL;
      end
      S_EVAL: begin
        node_d    = sum_rdata;
        tot_d     = p_tot;
        prod_d    = DataW'(len * p_tot);
        cov_d     = cov_w;
        outside_d = outside_w;
        state_d   = upd_w ? S_UPD : S_DECIDE;
      end
      S_UPD: begin
        // Apply the pending add to this node and clear it.
        sum_we     = 1'b1;
        sum_wdata  = node_q + prod_q;
        node_d     = node_q + prod_q;
        pend_we    = 1'b1;
        pend_wdata = '0;
        if (a_q != b_q) begin
          pend_raddr = left_nd;
          state_d    = S_CH0;
        end else begin
          state_d = S_DECIDE;
        end
      end
      S_CH0: begin
        pend_we    = 1'b1;
        pend_waddr = left_nd;
        pend_wdata = pend_rdata + tot_q;
        pend_raddr = right_nd;
        state_d    = S_CH1;
      end
      S_CH1: begin
        pend_we    = 1'b1;
        pend_waddr = right_nd;
        pend_wdata = pend_rdata + tot_q;
        state_d    = S_DECIDE;
      end
      S_DECIDE: begin
        if (outside_q) begin
          ret_d   = '0;
          state_d = S_RET;
        end else if (cov_q) begin
          ret_d   = node_q;
          state_d = S_RET;
        end else begin
          // Descend into the left child.
          push    = 1'b1;
          sp_d    = sp_q + SpW'(1);
          nd_d    = left_nd;
          b_d     = mid;
          state_d = S_VISIT;
        end
      end
      S_RET: begin
        if (sp_q == '0) begin
          state_d = (cmd_q == CmdSum) ? S_FIN : S_IDLE;
        end else if (!stk_ph_q[top_idx]) begin
          // Left half done: move on to the right child.
          set_right = 1'b1;
          nd_d      = top_right_nd;
          a_d       = top_mid + IdxW'(1);
          b_d       = stk_b_q[top_idx];
          state_d   = S_VISIT;
        end else begin
          // Both halves done: rebuild the parent's sum.
          acc_d   = stk_s_q[top_idx] + ret_q;
          nd_d    = stk_nd_q[top_idx];
          a_d     = stk_a_q[top_idx];
          b_d     = stk_b_q[top_idx];
          sp_d    = sp_dec;
          state_d = S_REFL;
        end
      end
      S_REFL: begin
        sum_raddr = left_nd;
        state_d   = S_REFR;
      end
      S_REFR: begin
        left_d    = sum_rdata;
        sum_raddr = right_nd;
        state_d   = S_REFW;
      end
      S_REFW: begin
        sum_we    = 1'b1;
        sum_wdata = left_q + sum_rdata;
        ret_d     = acc_q;
        state_d   = S_RET;
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          res_d       = ret_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_CLEAR;
      sp_q           <= '0;
      clr_q          <= '0;
      out_valid_q    <= 1'b0;
      active_count_q <= IndexW'(CountReset);
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        active_count_q <= cfg_wdata_i;
      end
    end
  end

  // Working payload registers.
  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    v_q       <= v_d;
    nd_q      <= nd_d;
    a_q       <= a_d;
    b_q       <= b_d;
    tot_q     <= tot_d;
    prod_q    <= prod_d;
    node_q    <= node_d;
    cov_q     <= cov_d;
    outside_q <= outside_d;
    ret_q     <= ret_d;
    acc_q     <= acc_d;
    left_q    <= left_d;
    res_q     <= res_d;
  end

  // Stack frames.
  always_ff @(posedge clk_i) begin
    if (push) begin
      stk_nd_q[push_idx] <= nd_q;
      stk_a_q[push_idx]  <= a_q;
      stk_b_q[push_idx]  <= b_q;
      stk_ph_q[push_idx] <= 1'b0;
    end
    if (set_right) begin
      stk_s_q[top_idx]  <= ret_q;
      stk_ph_q[top_idx] <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign range_sum_o = res_q;

  // The stack never grows past the tree height.
  assert property (@(posedge clk_i) disable iff (!rst_ni) sp_q <= SpW'(StackDepth))
    else $error("stack overflow");

  // Only a sum query produces a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) |-> (cmd_q == CmdSum))
    else $error("result from an add transaction");

  // No transaction is taken during the clearing pass.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> in_stall_o)
    else $error("input taken while clearing");

  // A new result is only loaded when the output register is free or draining.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i && state_q == S_FIN) |=> (state_q == S_FIN || !out_stall_i))
    else $error("result overwritten");

  // The sequencer state is always one-hot.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");

endmodule
